### rtl/ssort_pkg.sv
package ssort_pkg;

	localparam int unsigned DATA_W       = 32;
	localparam int unsigned CAPACITY_DEF = 64;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef struct packed {
		logic  occ;
		data_t val;
		logic  take;
	} link_t;

	typedef enum logic {
		ST_COLLECT,
		ST_DRAIN
	} state_t;

endpackage

### rtl/ssort_if.sv
interface ssort_in_if import ssort_pkg::*; ();
	logic  valid;
	logic  ready;
	data_t value;
	logic  is_last;

	modport source (output valid, output value, output is_last, input ready);
	modport sink (input valid, input value, input is_last, output ready);
endinterface

interface ssort_out_if import ssort_pkg::*; ();
	logic  valid;
	logic  ready;
	data_t sorted_value;
	logic  last_out;
	logic  overflow;

	modport source (output valid, output sorted_value, output last_out, output overflow,
		input ready);
	modport sink (input valid, input sorted_value, input last_out, input overflow,
		output ready);
endinterface

### rtl/selection_sort_engine_unit.sv
// channel | dir | fields                                        | beat
// --------+-----+-----------------------------------------------+---------------
// in_ch   | in  | value[31:0] signed, is_last                   | valid && ready
// out_ch  | out | sorted_value[31:0] signed, last_out, overflow | valid && ready
//
// Collect: one value a cycle, inserted in order into a row of CAPACITY cells.
// Drain: after the is_last beat the row shifts toward cell 0, one result a
// cycle; a run of N values holds in_ch.ready low for min(N, CAPACITY) result beats.
// A stalled out_ch freezes the row. Reset empties every cell and the count.
module selection_sort_engine_unit import ssort_pkg::*; #(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ssort_in_if.sink    in_ch,
	ssort_out_if.source out_ch
);

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q;
	logic               dropped_q;
	logic               in_beat, out_beat, full, insert, shift;
	link_t              lnk [CAPACITY];
	link_t              edge_link;

	assign edge_link = '{occ: 1'b0, val: '0, take: 1'b0};
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign in_beat   = in_ch.valid && in_ch.ready;
	assign out_beat  = out_ch.valid && out_ch.ready;
	assign insert    = in_beat && !full;
	assign shift     = out_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_ch.ready  = 1'b0;
		out_ch.valid = 1'b0;
		unique case (state_q)
			ST_COLLECT: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid && in_ch.is_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				out_ch.valid = 1'b1;
				if (out_ch.ready && out_ch.last_out) begin
					state_d = ST_COLLECT;
				end
			end
			default: state_d = ST_COLLECT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else begin
			if (in_beat && in_ch.is_last) begin
				count_q <= '0;
			end else if (insert) begin
				count_q <= count_q + 1'b1;
			end
			if (in_beat && full) begin
				dropped_q <= 1'b1;
			end else if (out_beat && out_ch.last_out) begin
				dropped_q <= 1'b0;
			end
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		link_t left_l, right_l;
		if (i == 0) begin : g_head
			assign left_l = edge_link;
		end else begin : g_mid_l
			assign left_l = lnk[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_l = edge_link;
		end else begin : g_mid_r
			assign right_l = lnk[i+1];
		end
		ssort_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.insert (insert),
			.shift  (shift),
			.din    (in_ch.value),
			.left   (left_l),
			.right  (right_l),
			.link   (lnk[i])
		);
	end

	assign out_ch.sorted_value = lnk[0].val;
	assign out_ch.last_out     = !lnk[1].occ;
	assign out_ch.overflow     = dropped_q;

endmodule

### rtl/ssort_cell.sv
module ssort_cell import ssort_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  insert,
	input  logic  shift,
	input  data_t din,
	input  link_t left,
	input  link_t right,
	output link_t link
);

	logic  occ_q;
	data_t val_q;
	logic  take;

	assign take = !occ_q || (val_q > din);

	always_comb begin
		link.occ  = occ_q;
		link.val  = val_q;
		link.take = take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (insert && take) begin
			occ_q <= left.take ? left.occ : 1'b1;
		end else if (shift) begin
			occ_q <= right.occ;
		end
	end

	always_ff @(posedge clk) begin
		if (insert && take) begin
			val_q <= left.take ? left.val : din;
		end else if (shift) begin
			val_q <= right.val;
		end
	end

endmodule

### rtl/ssort_chk.sv
module ssort_chk import ssort_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  in_valid,
	input logic  in_ready,
	input logic  in_is_last,
	input logic  out_valid,
	input logic  out_ready,
	input data_t out_sorted_value,
	input logic  out_last_out
);

	a_phase_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output open together");

	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_is_last |=> out_valid)
		else $error("no result after last beat");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last_out |=> !out_valid && in_ready)
		else $error("drain did not end");

	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last_out |=>
			out_valid && (out_sorted_value >= $past(out_sorted_value)))
		else $error("results out of order");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_sorted_value))
		else $error("stalled result changed");

endmodule

bind selection_sort_engine_unit ssort_chk u_ssort_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_ch.valid),
	.in_ready         (in_ch.ready),
	.in_is_last       (in_ch.is_last),
	.out_valid        (out_ch.valid),
	.out_ready        (out_ch.ready),
	.out_sorted_value (out_ch.sorted_value),
	.out_last_out     (out_ch.last_out)
);

### bench/sort_order_check.sv
module sort_order_check import ssort_pkg::*; #(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	ssort_in_if   in_mon,
	ssort_out_if  out_mon,
	output int    mismatches,
	output int    due_count
);

	typedef struct packed {
		data_t sorted_value;
		logic  last_out;
		logic  overflow;
	} sorted_beat_t;

	data_t        run_values[$];
	logic         run_dropped;
	sorted_beat_t sorted_due[$];

	initial begin
		mismatches  = 0;
		due_count   = 0;
		run_dropped = 1'b0;
	end

	always @(posedge clk) begin : track
		sorted_beat_t due;
		data_t        swap;
		int           pick;
		if (arst_n) begin
			if (out_mon.valid && out_mon.ready) begin
				if (sorted_due.size() == 0) begin
					$error("sorted_value: expected no beat, got %0d", out_mon.sorted_value);
					mismatches++;
				end else begin
					due = sorted_due.pop_front();
					if (out_mon.sorted_value !== due.sorted_value) begin
						$error("sorted_value: expected %0d, got %0d",
							due.sorted_value, out_mon.sorted_value);
						mismatches++;
					end
					if (out_mon.last_out !== due.last_out) begin
						$error("last_out: expected %0b, got %0b", due.last_out, out_mon.last_out);
						mismatches++;
					end
					if (out_mon.overflow !== due.overflow) begin
						$error("overflow: expected %0b, got %0b", due.overflow, out_mon.overflow);
						mismatches++;
					end
				end
			end
			if (in_mon.valid && in_mon.ready) begin
				if (run_values.size() < CAPACITY) begin
					run_values = {run_values, in_mon.value};
				end else begin
					run_dropped = 1'b1;
				end
				if (in_mon.is_last) begin
					for (int i = 0; i < run_values.size(); i++) begin
						pick = i;
						for (int j = i + 1; j < run_values.size(); j++) begin
							if (run_values[j] < run_values[pick]) begin
								pick = j;
							end
						end
						swap             = run_values[i];
						run_values[i]    = run_values[pick];
						run_values[pick] = swap;
					end
					foreach (run_values[k]) begin
						due.sorted_value = run_values[k];
						due.last_out     = (k == run_values.size() - 1);
						due.overflow     = run_dropped;
						sorted_due       = {sorted_due, due};
					end
					run_values.delete();
					run_dropped = 1'b0;
				end
			end
			due_count = sorted_due.size();
		end
	end

endmodule

### bench/testbench.sv
module testbench import ssort_pkg::*; ();

	localparam int unsigned CAPACITY    = CAPACITY_DEF;
	localparam int          ITEM_GOAL   = 230;
	localparam int          IDLE_PCT    = 6;
	localparam int          DRAIN_SLACK = 50;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam data_t       VAL_MIN     = {1'b1, {(DATA_W - 1){1'b0}}};
	localparam data_t       VAL_MAX     = {1'b0, {(DATA_W - 1){1'b1}}};

	logic clk;
	logic arst_n;
	logic no_idle;
	int   items_sent;
	int   mismatches;
	int   due_count;

	ssort_in_if  in_ch ();
	ssort_out_if out_ch ();

	selection_sort_engine_unit #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch)
	);

	sort_order_check #(
		.CAPACITY(CAPACITY)
	) i_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_mon    (in_ch),
		.out_mon   (out_ch),
		.mismatches(mismatches),
		.due_count (due_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin : watchdog
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	function automatic data_t pick_value();
		case ($urandom_range(9))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2, 3: return data_t'(int'($urandom_range(8)) - 4);
			default: return data_t'($urandom);
		endcase
	endfunction

	task automatic send_beat(input data_t value, input logic is_last);
		if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.value   <= value;
		in_ch.is_last <= is_last;
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
	endtask

	task automatic send_run(input int len);
		for (int i = 0; i < len; i++) begin
			send_beat(pick_value(), i == len - 1);
		end
	endtask

	initial begin : stimulus
		int run_idx;
		arst_n        = 1'b0;
		no_idle       = 1'b0;
		items_sent    = 0;
		in_ch.valid   = 1'b0;
		in_ch.value   = '0;
		in_ch.is_last = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(VAL_MAX, 1'b1);
		send_beat(VAL_MIN, 1'b1);

		send_beat(32'sd0, 1'b0);
		send_beat(-32'sd1, 1'b0);
		send_beat(32'sd1, 1'b0);
		send_beat(data_t'(32'h5555_5555), 1'b0);
		send_beat(data_t'(32'hAAAA_AAAA), 1'b0);
		send_beat(VAL_MAX, 1'b0);
		send_beat(VAL_MIN, 1'b1);

		send_beat(32'sd7, 1'b0);
		send_beat(32'sd7, 1'b0);
		send_beat(-32'sd3, 1'b0);
		send_beat(32'sd7, 1'b1);

		for (int i = 5; i >= 1; i--) begin
			send_beat(data_t'(i), i == 1);
		end
		send_beat(-32'sd2, 1'b0);
		send_beat(32'sd0, 1'b0);
		send_beat(32'sd2, 1'b1);

		in_ch.valid <= 1'b0;
		@(posedge clk);
		wait (due_count == 0);
		@(posedge clk);

		run_idx = 0;
		while (items_sent < ITEM_GOAL || run_idx < 10) begin
			if (run_idx == 3) begin
				no_idle = 1'b1;
				send_run(CAPACITY);
				no_idle = 1'b0;
			end else if (run_idx == 8) begin
				send_run(CAPACITY + 3);
			end else begin
				send_run($urandom_range(1, 9));
			end
			run_idx++;
		end
		in_ch.valid <= 1'b0;

		@(posedge clk);
		wait (due_count == 0);
		repeat (DRAIN_SLACK) @(posedge clk);
		if (mismatches == 0 && due_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### sim.f
rtl/ssort_pkg.sv
rtl/ssort_if.sv
rtl/ssort_cell.sv
rtl/selection_sort_engine_unit.sv
rtl/ssort_chk.sv
bench/sort_order_check.sv
bench/testbench.sv
